### design/radix_string_to_int_saturating_unit_macros.svh
// Assertion macros shared by the string-to-integer converter modules.
// Depends on a clock named clk_i and an active-low reset named rst_ni in scope.
`ifndef RADIX_STRING_TO_INT_SATURATING_UNIT_MACROS_SVH
`define RADIX_STRING_TO_INT_SATURATING_UNIT_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define RSTSI_ASSERT_IMPL(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("rstsi: same-cycle check failed");

// Next-cycle implication, checked outside reset.
`define RSTSI_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("rstsi: next-cycle check failed");

`endif

### design/rstsi_pkg.sv
// Package for the string-to-integer converter: payload types, classified
// byte token, character codes and saturation limits. No dependencies.
package rstsi_pkg;

  localparam int unsigned ChW     = 8;
  localparam int unsigned RadixW  = 6;
  localparam int unsigned ValW    = 32;
  localparam int unsigned EndW    = 16;
  localparam int unsigned PosBits = 16;

  // Depth of the queue between front and back.
  localparam int unsigned QDepth = 2;
  localparam int unsigned QPtrW  = (QDepth > 1) ? $clog2(QDepth) : 1;
  localparam int unsigned QCntW  = $clog2(QDepth + 1);

  // Configuration register indexes.
  localparam logic CfgIdxRadix    = 1'b0;
  localparam logic CfgIdxUnsigned = 1'b1;
  localparam logic [RadixW-1:0] RadixReset = RadixW'(10);

  // Character codes.
  localparam logic [ChW-1:0] ChTab   = 8'h09;
  localparam logic [ChW-1:0] ChCr    = 8'h0D;
  localparam logic [ChW-1:0] ChSpace = 8'h20;
  localparam logic [ChW-1:0] ChPlus  = 8'h2B;
  localparam logic [ChW-1:0] ChMinus = 8'h2D;
  localparam logic [ChW-1:0] ChZero  = 8'h30;
  localparam logic [ChW-1:0] ChNine  = 8'h39;
  localparam logic [ChW-1:0] ChUpA   = 8'h41;
  localparam logic [ChW-1:0] ChUpZ   = 8'h5A;
  localparam logic [ChW-1:0] ChLoA   = 8'h61;
  localparam logic [ChW-1:0] ChLoZ   = 8'h7A;
  localparam logic [ChW-1:0] ChUpX   = 8'h58;
  localparam logic [ChW-1:0] ChLoX   = 8'h78;

  // Digit code for a byte that is no digit at all; above every valid base.
  localparam logic [RadixW-1:0] DigitNone = '1;

  // Bases.
  localparam logic [RadixW-1:0] BaseAuto = RadixW'(0);
  localparam logic [RadixW-1:0] BaseBad  = RadixW'(1);
  localparam logic [RadixW-1:0] BaseOct  = RadixW'(8);
  localparam logic [RadixW-1:0] BaseDec  = RadixW'(10);
  localparam logic [RadixW-1:0] BaseHex  = RadixW'(16);
  localparam logic [RadixW-1:0] BaseMax  = RadixW'(36);

  // Saturation limits.
  localparam logic [ValW-1:0] SatUnsigned = 32'hFFFF_FFFF;
  localparam logic [ValW-1:0] SatNegative = 32'h8000_0000;
  localparam logic [ValW-1:0] SatPositive = 32'h7FFF_FFFF;

  typedef struct packed {
    logic [ChW-1:0] ch;
    logic           first;
  } rstsi_in_t;

  typedef struct packed {
    logic [ValW-1:0] value;
    logic [EndW-1:0] end_offset;
    logic            range_error;
  } rstsi_out_t;

  // One byte after classification by the front.
  typedef struct packed {
    logic              first;
    logic              is_space;
    logic              is_minus;
    logic              is_plus;
    logic              is_zero;
    logic              is_x;
    logic [RadixW-1:0] digit;
  } rstsi_tok_t;

  typedef struct packed {
    logic [RadixW-1:0] radix;
    logic              unsigned_mode;
  } rstsi_cfg_t;

endpackage

### design/radix_string_to_int_saturating_unit.sv
// Top level of the streaming string-to-integer converter with saturation.
// Depends on rstsi_pkg, rstsi_front, rstsi_fifo and rstsi_back.
//
//   Channel  | Signals                              | Moves
//   ---------+--------------------------------------+----------------------------
//   input    | push_i, full_o, in_i                 | one byte and its first flag
//   result   | empty_o, pop_i, out_o                | value, end offset, range flag
//   config   | cfg_we_i, cfg_idx_i, cfg_data_i      | radix, unsigned mode
//
// The back steps each byte through the single multiply-add by the base in the
// digit step. A byte is written into the two-entry queue at the edge that
// accepts it; the back then takes it from the queue and registers the result.
// A waiting result stalls the back only; the queue keeps taking bytes until full.
// Reset is asynchronous and leaves the block idle with radix 10, signed mode.
module radix_string_to_int_saturating_unit (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  input  logic                                   push_i,
  output logic                                   full_o,
  input  rstsi_pkg::rstsi_in_t                   in_i,
  output logic                                   empty_o,
  input  logic                                   pop_i,
  output rstsi_pkg::rstsi_out_t                  out_o,
  input  logic                                   cfg_we_i,
  input  logic                                   cfg_idx_i,
  input  logic [rstsi_pkg::RadixW-1:0]           cfg_data_i
);
  import rstsi_pkg::*;

  rstsi_cfg_t cfg_q;
  rstsi_tok_t front_tok, q_tok;
  logic       front_push, q_full, q_empty, back_pop;

  // Configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.radix         <= RadixReset;
      cfg_q.unsigned_mode <= 1'b0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CfgIdxRadix:    cfg_q.radix         <= cfg_data_i;
        CfgIdxUnsigned: cfg_q.unsigned_mode <= cfg_data_i[0];
        default: begin
        end
      endcase
    end
  end

  assign full_o = q_full;

  rstsi_front u_front (
    .in_i       (in_i),
    .push_i     (push_i),
    .q_full_i   (q_full),
    .tok_o      (front_tok),
    .tok_push_o (front_push)
  );

  rstsi_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (front_push),
    .data_i  (front_tok),
    .full_o  (q_full),
    .pop_i   (back_pop),
    .data_o  (q_tok),
    .empty_o (q_empty)
  );

  rstsi_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .tok_i       (q_tok),
    .tok_valid_i (!q_empty),
    .tok_pop_o   (back_pop),
    .out_o       (out_o),
    .empty_o     (empty_o),
    .pop_i       (pop_i)
  );

endmodule

### design/rstsi_front.sv
// Front of the converter: classifies each incoming byte into a token.
// Depends on rstsi_pkg.
module rstsi_front (
  input  rstsi_pkg::rstsi_in_t  in_i,
  input  logic                  push_i,
  input  logic                  q_full_i,
  output rstsi_pkg::rstsi_tok_t tok_o,
  output logic                  tok_push_o
);
  import rstsi_pkg::*;

  logic [ChW-1:0] ch;

  assign ch = in_i.ch;

  // Byte classes and digit value.
  always_comb begin
    tok_o.first    = in_i.first;
    tok_o.is_space = ((ch >= ChTab) && (ch <= ChCr)) || (ch == ChSpace);
    tok_o.is_minus = (ch == ChMinus);
    tok_o.is_plus  = (ch == ChPlus);
    tok_o.is_zero  = (ch == ChZero);
    tok_o.is_x     = (ch == ChUpX) || (ch == ChLoX);
    if ((ch >= ChZero) && (ch <= ChNine)) begin
      tok_o.digit = RadixW'(ch - ChZero);
    end else if ((ch >= ChUpA) && (ch <= ChUpZ)) begin
      tok_o.digit = RadixW'(ch - ChUpA + 8'd10);
    end else if ((ch >= ChLoA) && (ch <= ChLoZ)) begin
      tok_o.digit = RadixW'(ch - ChLoA + 8'd10);
    end else begin
      tok_o.digit = DigitNone;
    end
  end

  // A request is taken when the queue has room.
  assign tok_push_o = push_i && !q_full_i;

endmodule

### design/rstsi_fifo.sv
// Short token queue between the front and the back of the converter.
// Depends on rstsi_pkg and the assertion macro header.
`include "radix_string_to_int_saturating_unit_macros.svh"

module rstsi_fifo (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  push_i,
  input  rstsi_pkg::rstsi_tok_t data_i,
  output logic                  full_o,
  input  logic                  pop_i,
  output rstsi_pkg::rstsi_tok_t data_o,
  output logic                  empty_o
);
  import rstsi_pkg::*;

  rstsi_tok_t       store_q [QDepth];
  logic [QPtrW-1:0] wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [QCntW-1:0] count_q, count_d;
  logic             do_push, do_pop;

  assign full_o  = (count_q == QCntW'(QDepth));
  assign empty_o = (count_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign data_o  = store_q[rd_ptr_q];

  // Pointer and fill count update.
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == QPtrW'(QDepth - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == QPtrW'(QDepth - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_d = count_q + 1'b1;
    end else if (do_pop && !do_push) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  // Token storage.
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      store_q[wr_ptr_q] <= data_i;
    end
  end

  `RSTSI_ASSERT_IMPL(a_count_bound, 1'b1, count_q <= QCntW'(QDepth))
  `RSTSI_ASSERT_NEXT(a_count_up, do_push && !do_pop, count_q == $past(count_q) + 1'b1)
  `RSTSI_ASSERT_NEXT(a_count_down, do_pop && !do_push, count_q == $past(count_q) - 1'b1)

endmodule

### design/rstsi_back.sv
// Back of the converter: parses tokens, accumulates digits, saturates and
// holds the result register. Depends on rstsi_pkg and the macro header.
`include "radix_string_to_int_saturating_unit_macros.svh"

module rstsi_back (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  rstsi_pkg::rstsi_cfg_t cfg_i,
  input  rstsi_pkg::rstsi_tok_t tok_i,
  input  logic                  tok_valid_i,
  output logic                  tok_pop_o,
  output rstsi_pkg::rstsi_out_t out_o,
  output logic                  empty_o,
  input  logic                  pop_i
);
  import rstsi_pkg::*;

  typedef enum logic [2:0] {
    PhIdle,
    PhLead,
    PhSigned,
    PhZero,
    PhXpref,
    PhDigits
  } phase_e;

  localparam int unsigned ProdW = ValW + RadixW + 1;

  phase_e              phase_q, phase_d;
  logic [ValW-1:0]     acc_q, acc_d;
  logic [RadixW-1:0]   base_q, base_d;
  logic                neg_q, neg_d;
  logic                ovf_q, ovf_d;
  logic                seen_q, seen_d;
  logic [PosBits-1:0]  pos_q, pos_d;
  logic                out_valid_q, out_valid_d;
  rstsi_out_t          out_q, out_d;

  // Working copies inside the step logic.
  phase_e              ph;
  logic [ValW-1:0]     acc;
  logic [RadixW-1:0]   base;
  logic                neg, ovf, seen;
  logic [PosBits-1:0]  cur_pos;
  logic                begin_num, feed, fin, out_ready;
  logic [ProdW-1:0]    prod;
  logic [ValW-1:0]     res_val;
  logic                res_err;

  assign out_ready = !out_valid_q || pop_i;
  assign tok_pop_o = tok_valid_i && out_ready;
  assign out_o     = out_q;
  assign empty_o   = !out_valid_q;

  // One token per cycle if out_ready: restart, prefix, digit step, finish.
  always_comb begin
    phase_d     = phase_q;
    acc_d       = acc_q;
    base_d      = base_q;
    neg_d       = neg_q;
    ovf_d       = ovf_q;
    seen_d      = seen_q;
    pos_d       = pos_q;
    out_valid_d = out_valid_q && !pop_i;
    out_d       = out_q;
    ph          = phase_q;
    acc         = acc_q;
    base        = base_q;
    neg         = neg_q;
    ovf         = ovf_q;
    seen        = seen_q;
    cur_pos     = pos_q;
    begin_num   = 1'b0;
    feed        = 1'b0;
    fin         = 1'b0;
    prod        = '0;
    res_val     = '0;
    res_err     = 1'b0;
    if (tok_pop_o) begin
      if (tok_i.first) begin
        ph      = PhLead;
        acc     = '0;
        base    = cfg_i.radix;
        neg     = 1'b0;
        ovf     = 1'b0;
        seen    = 1'b0;
        cur_pos = '0;
      end
      if (ph != PhIdle) begin
        pos_d = PosBits'(cur_pos + 1'b1);
        unique case (ph)
          PhIdle: begin
          end
          PhLead: begin
            if (tok_i.is_space) begin
            end else if (tok_i.is_minus) begin
              neg = 1'b1;
              ph  = PhSigned;
            end else if (tok_i.is_plus) begin
              ph = PhSigned;
            end else begin
              begin_num = 1'b1;
            end
          end
          PhSigned: begin
            begin_num = 1'b1;
          end
          PhZero: begin
            if (tok_i.is_x) begin
              base = BaseHex;
              ph   = PhXpref;
            end else begin
              base = (base == BaseAuto) ? BaseOct : BaseHex;
              seen = 1'b1;
              acc  = '0;
              ph   = PhDigits;
              feed = 1'b1;
            end
          end
          PhXpref, PhDigits: begin
            feed = 1'b1;
          end
          default: begin
            ph = PhIdle;
          end
        endcase

        // Start of the number proper: base check and leading zero.
        if (begin_num) begin
          if ((base == BaseBad) || (base > BaseMax)) begin
            fin = 1'b1;
          end else if (tok_i.is_zero && ((base == BaseAuto) || (base == BaseHex))) begin
            ph = PhZero;
          end else begin
            if (base == BaseAuto) begin
              base = BaseDec;
            end
            ph   = PhDigits;
            feed = 1'b1;
          end
        end

        // Digit step: multiply-add by the base, sticky overflow.
        if (feed) begin
          if (tok_i.digit >= base) begin
            fin = 1'b1;
          end else begin
            seen = 1'b1;
            prod = ProdW'(acc) * ProdW'(base) + ProdW'(tok_i.digit);
            if (!ovf && (prod[ProdW-1:ValW] == '0)) begin
              acc = prod[ValW-1:0];
            end else begin
              ovf = 1'b1;
            end
          end
        end

        // Terminating byte: saturate, negate and emit.
        if (fin) begin
          if (seen) begin
            res_val = acc;
            if (ovf || (!cfg_i.unsigned_mode &&
                        (neg ? (acc > SatNegative) : (acc > SatPositive)))) begin
              res_err = 1'b1;
              res_val = cfg_i.unsigned_mode ? SatUnsigned :
                        (neg ? SatNegative : SatPositive);
            end
            if (neg) begin
              res_val = '0 - res_val;
            end
            out_d.end_offset = EndW'(32'(cur_pos));
          end else begin
            out_d.end_offset = '0;
          end
          out_d.value       = res_val;
          out_d.range_error = res_err;
          out_valid_d       = 1'b1;
          ph                = PhIdle;
        end
      end
      phase_d = ph;
      acc_d   = acc;
      base_d  = base;
      neg_d   = neg;
      ovf_d   = ovf;
      seen_d  = seen;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= PhIdle;
      acc_q       <= '0;
      base_q      <= '0;
      neg_q       <= 1'b0;
      ovf_q       <= 1'b0;
      seen_q      <= 1'b0;
      pos_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      phase_q     <= phase_d;
      acc_q       <= acc_d;
      base_q      <= base_d;
      neg_q       <= neg_d;
      ovf_q       <= ovf_d;
      seen_q      <= seen_d;
      pos_q       <= pos_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Result payload.
  always_ff @(posedge clk_i) begin
    out_q <= out_d;
  end

  `RSTSI_ASSERT_IMPL(a_digits_seen, phase_q == PhDigits, seen_q)
  `RSTSI_ASSERT_IMPL(a_ovf_seen, ovf_q, seen_q)
  `RSTSI_ASSERT_IMPL(a_sat_value, out_valid_q && out_q.range_error,
    (out_q.value == SatUnsigned) || (out_q.value == 32'h0000_0001) ||
    (out_q.value == SatNegative) || (out_q.value == SatPositive) ||
    (out_q.value == 32'h8000_0001))

endmodule

### test/tb_top.sv
// Self-checking testbench for the streaming string-to-integer converter with saturation.
// Depends on rstsi_pkg and radix_string_to_int_saturating_unit; drives requests from a
// queue, predicts each conversion in step with the input and checks every result.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import rstsi_pkg::*;

  localparam int unsigned LimitCycles  = 600000;
  localparam int unsigned SettleCycles = 16;
  localparam int unsigned HoldCycles   = 400;
  localparam int          GapMax       = 12;
  localparam int unsigned PhaseBytes   = 128;
  localparam int unsigned NumPhases    = 12;

  localparam logic [ChW-1:0] ChNul   = 8'h00;
  localparam logic [ChW-1:0] ChComma = 8'h2C;
  localparam logic [ChW-1:0] ChBang  = 8'h21;

  // Parser phases of the predictor.
  typedef enum logic [2:0] {
    ScanIdle,
    ScanLead,
    ScanSigned,
    ScanZero,
    ScanPrefix,
    ScanDigits
  } scan_e;

  logic              clk_i      = 1'b0;
  logic              rst_ni     = 1'b0;
  logic              push_i     = 1'b0;
  logic              full_o;
  rstsi_in_t         in_i       = '0;
  logic              empty_o;
  logic              pop_i      = 1'b0;
  rstsi_out_t        out_o;
  logic              cfg_we_i   = 1'b0;
  logic              cfg_idx_i  = 1'b0;
  logic [RadixW-1:0] cfg_data_i = '0;

  // Predictor state and its copy of the registers.
  scan_e              scan_state   = ScanIdle;
  logic [ValW-1:0]    mag_acc      = '0;
  logic [RadixW-1:0]  cur_base     = '0;
  logic               saw_minus    = 1'b0;
  logic               mag_ovf      = 1'b0;
  logic               saw_digit    = 1'b0;
  logic [PosBits-1:0] byte_pos     = '0;
  logic [RadixW-1:0]  cfg_radix    = RadixReset;
  logic               cfg_unsigned = 1'b0;

  rstsi_in_t  pending_bytes[$];
  rstsi_out_t expected_conversions[$];

  int          error_count   = 0;
  int          tx_gap_max    = 0;
  int          rx_gap_max    = 0;
  int unsigned tx_wait       = 0;
  int unsigned rx_wait       = 0;
  int unsigned hold_requests = 0;
  int unsigned holds_taken   = 0;
  int unsigned hold_left     = 0;
  int unsigned cycle_count   = 0;

  radix_string_to_int_saturating_unit dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (push_i),
    .full_o     (full_o),
    .in_i       (in_i),
    .empty_o    (empty_o),
    .pop_i      (pop_i),
    .out_o      (out_o),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i)
  );

  // Free-running clock, 4 ns period.
  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  // Digit weight of a byte; bytes that are no digit get a weight above every base.
  function automatic int unsigned digit_of(input logic [ChW-1:0] c);
    if (c >= ChZero && c <= ChNine) return c - ChZero;
    if (c >= ChUpA && c <= ChUpZ) return c - ChUpA + 10;
    if (c >= ChLoA && c <= ChLoZ) return c - ChLoA + 10;
    return 99;
  endfunction

  // Character for a digit weight, letters in either case.
  function automatic logic [ChW-1:0] digit_char(input int unsigned d);
    if (d < 10) return ChZero + ChW'(d);
    return ($urandom_range(0, 1) ? ChUpA : ChLoA) + ChW'(d - 10);
  endfunction

  // Close the number: saturate, negate and queue the expected conversion.
  task automatic finish_conversion(input logic [PosBits-1:0] pos);
    rstsi_out_t res;
    res = '0;
    if (saw_digit) begin
      res.value      = mag_acc;
      res.end_offset = pos[EndW-1:0];
      if (mag_ovf || (!cfg_unsigned &&
                      (saw_minus ? mag_acc > SatNegative : mag_acc > SatPositive))) begin
        res.range_error = 1'b1;
        res.value = cfg_unsigned ? SatUnsigned : (saw_minus ? SatNegative : SatPositive);
      end
      if (saw_minus) res.value = -res.value;
    end
    expected_conversions.push_back(res);
    scan_state = ScanIdle;
  endtask

  // Accumulate one digit, or end the number on a byte that is no digit in the base.
  task automatic take_digit(input logic [ChW-1:0] c, input logic [PosBits-1:0] pos);
    int unsigned d;
    logic [63:0] nxt;
    d = digit_of(c);
    if (d >= cur_base) begin
      finish_conversion(pos);
    end else begin
      saw_digit = 1'b1;
      nxt = 64'(mag_acc) * 64'(cur_base) + 64'(d);
      if (!mag_ovf && nxt <= 64'hFFFF_FFFF) mag_acc = nxt[ValW-1:0];
      else mag_ovf = 1'b1;
    end
  endtask

  // First byte after whitespace and sign: check the base, look for a zero prefix.
  task automatic start_number(input logic [ChW-1:0] c, input logic [PosBits-1:0] pos);
    if (cur_base == BaseBad || cur_base > BaseMax) begin
      finish_conversion(pos);
    end else if (c == ChZero && (cur_base == BaseAuto || cur_base == BaseHex)) begin
      scan_state = ScanZero;
    end else begin
      if (cur_base == BaseAuto) cur_base = BaseDec;
      scan_state = ScanDigits;
      take_digit(c, pos);
    end
  endtask

  // Advance the predictor by one accepted request.
  task automatic predict_byte(input rstsi_in_t req);
    logic [PosBits-1:0] here;
    if (req.first) begin
      scan_state = ScanLead;
      mag_acc    = '0;
      cur_base   = cfg_radix;
      saw_minus  = 1'b0;
      mag_ovf    = 1'b0;
      saw_digit  = 1'b0;
      byte_pos   = '0;
    end
    if (scan_state != ScanIdle) begin
      here     = byte_pos;
      byte_pos = byte_pos + 1'b1;
      case (scan_state)
        ScanLead: begin
          if ((req.ch >= ChTab && req.ch <= ChCr) || req.ch == ChSpace) begin
            // Leading whitespace is skipped.
          end else if (req.ch == ChMinus) begin
            saw_minus  = 1'b1;
            scan_state = ScanSigned;
          end else if (req.ch == ChPlus) begin
            scan_state = ScanSigned;
          end else begin
            start_number(req.ch, here);
          end
        end
        ScanSigned: start_number(req.ch, here);
        ScanZero: begin
          if (req.ch == ChLoX || req.ch == ChUpX) begin
            cur_base   = BaseHex;
            scan_state = ScanPrefix;
          end else begin
            cur_base   = (cur_base == BaseAuto) ? BaseOct : BaseHex;
            saw_digit  = 1'b1;
            mag_acc    = '0;
            scan_state = ScanDigits;
            take_digit(req.ch, here);
          end
        end
        ScanPrefix, ScanDigits: take_digit(req.ch, here);
        default: scan_state = ScanIdle;
      endcase
    end
  endtask

  task automatic queue_byte(input logic [ChW-1:0] ch, input logic first);
    rstsi_in_t req;
    req.ch    = ch;
    req.first = first;
    pending_bytes.push_back(req);
  endtask

  // Queue one string: mostly well-formed numbers, some broken strings and stray bytes.
  // Returns the number of bytes that belong to a string.
  task automatic queue_string(output int unsigned n);
    logic [ChW-1:0] text[$];
    int unsigned    digs[$];
    logic [63:0]    target;
    int unsigned    eff, count, mode, kind, pick;
    kind = $urandom_range(0, 9);
    n = 0;
    if (kind == 0) begin
      // Stray bytes without a start flag.
      repeat ($urandom_range(1, 3)) queue_byte(ChW'($urandom), 1'b0);
    end else if (kind == 1) begin
      // Random bytes, now and then restarting in the middle.
      count = $urandom_range(1, 6);
      for (pick = 0; pick < count; pick++) begin
        queue_byte(ChW'($urandom), (pick == 0) || ($urandom_range(0, 7) == 0));
      end
      n = count;
    end else begin
      repeat ($urandom_range(0, 3)) begin
        pick = $urandom_range(0, 5);
        text.push_back((pick == 5) ? ChSpace : ChTab + ChW'(pick));
      end
      case ($urandom_range(0, 2))
        1: text.push_back(ChPlus);
        2: text.push_back(ChMinus);
        default: ;
      endcase
      // Digits are drawn in the base the block will settle on; invalid bases get any.
      eff = (cfg_radix >= 2 && cfg_radix <= BaseMax) ? cfg_radix : 36;
      if (cfg_radix == BaseAuto || cfg_radix == BaseHex) begin
        mode = $urandom_range(0, 2);
        if (cfg_radix == BaseAuto) eff = (mode == 0) ? 10 : ((mode == 1) ? 8 : 16);
        if (mode != 0) text.push_back(ChZero);
        if (mode == 2) text.push_back($urandom_range(0, 1) ? ChLoX : ChUpX);
      end
      mode = $urandom_range(0, 9);
      if (mode == 1 || mode == 2) begin
        // Magnitudes at the saturation limits.
        case ($urandom_range(0, 5))
          0: target = 64'h0000_0000_7FFF_FFFF;
          1: target = 64'h0000_0000_8000_0000;
          2: target = 64'h0000_0000_8000_0001;
          3: target = 64'h0000_0000_FFFF_FFFF;
          4: target = 64'h0000_0001_0000_0000;
          default: target = {32'h0, $urandom()};
        endcase
        do begin
          digs.push_front(int'(target % eff));
          target = target / eff;
        end while (target != 0);
      end else if (mode != 0) begin
        count = (mode == 3) ? $urandom_range(9, 14) : $urandom_range(1, 6);
        repeat (count) digs.push_back($urandom_range(0, eff - 1));
      end
      foreach (digs[i]) text.push_back(digit_char(digs[i]));
      // Terminator; left off now and then so that the next start abandons the parse.
      if ($urandom_range(0, 15) != 0) begin
        case ($urandom_range(0, 3))
          0: text.push_back(ChNul);
          1: text.push_back(ChSpace);
          2: text.push_back(ChW'($urandom));
          default: text.push_back(ChComma);
        endcase
      end
      foreach (text[i]) queue_byte(text[i], i == 0);
      n = text.size();
    end
  endtask

  // Wait until every request has gone in and every conversion has come out.
  task automatic drain();
    while (pending_bytes.size() != 0 || push_i || expected_conversions.size() != 0) begin
      @(posedge clk_i);
    end
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  // Write both registers; only called while the block is idle.
  task automatic write_config(input logic [RadixW-1:0] radix, input logic uns);
    @(posedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= CfgIdxRadix;
    cfg_data_i <= radix;
    @(posedge clk_i);
    cfg_idx_i  <= CfgIdxUnsigned;
    cfg_data_i <= RadixW'({$urandom, uns});
    @(posedge clk_i);
    cfg_we_i   <= 1'b0;
    cfg_radix    = radix;
    cfg_unsigned = uns;
  endtask

  // One random phase under one register setting.
  task automatic run_phase(input logic [RadixW-1:0] radix, input logic uns,
                           input int tx_max, input int rx_max);
    int unsigned added, n;
    drain();
    write_config(radix, uns);
    tx_gap_max = tx_max;
    rx_gap_max = rx_max;
    added = 0;
    while (added < PhaseBytes) begin
      queue_string(n);
      added += n;
    end
    // A start byte that is no digit abandons any open string and yields a result of its own.
    queue_byte(ChBang, 1'b1);
  endtask

  // Request driver: offers queued bytes with random gaps and feeds the predictor.
  always @(posedge clk_i) begin : drive_requests
    logic      offer;
    rstsi_in_t next_req;
    if (!rst_ni) begin
      push_i <= 1'b0;
    end else begin
      offer    = push_i;
      next_req = in_i;
      if (push_i && !full_o) begin
        predict_byte(in_i);
        offer = 1'b0;
      end
      if (!offer) begin
        if (tx_wait != 0) begin
          tx_wait--;
        end else if (pending_bytes.size() != 0) begin
          next_req = pending_bytes.pop_front();
          offer    = 1'b1;
          tx_wait  = $urandom_range(0, tx_gap_max);
        end
      end
      push_i <= offer;
      in_i   <= next_req;
    end
  end

  // Result monitor: pops with random stalls and compares against the oldest prediction.
  always @(posedge clk_i) begin : collect_results
    rstsi_out_t want;
    if (!rst_ni) begin
      pop_i <= 1'b0;
    end else begin
      if (pop_i && !empty_o) begin
        if (expected_conversions.size() == 0) begin
          if (error_count < 10) begin
            $display("mismatch: unexpected result value %h end %0d range %b",
                     out_o.value, out_o.end_offset, out_o.range_error);
          end
          error_count++;
        end else begin
          want = expected_conversions.pop_front();
          if (out_o.value !== want.value || out_o.end_offset !== want.end_offset ||
              out_o.range_error !== want.range_error) begin
            if (error_count < 10) begin
              $display("mismatch: expected value %h end %0d range %b, got %h end %0d range %b",
                       want.value, want.end_offset, want.range_error,
                       out_o.value, out_o.end_offset, out_o.range_error);
            end
            error_count++;
          end
        end
        rx_wait = $urandom_range(0, rx_gap_max);
      end
      if (hold_requests != holds_taken) begin
        holds_taken = hold_requests;
        hold_left   = HoldCycles;
      end
      if (hold_left != 0) begin
        hold_left--;
        pop_i <= 1'b0;
      end else if (rx_wait != 0) begin
        rx_wait--;
        pop_i <= 1'b0;
      end else begin
        pop_i <= 1'b1;
      end
    end
  end

  // Watchdog on the total run length.
  always @(posedge clk_i) begin : watchdog
    cycle_count++;
    if (cycle_count == LimitCycles) begin
      $display("tb_top: errors");
      $finish;
    end
  end

  // Test sequence: reset, directed strings, then random phases.
  initial begin : stimulus
    int unsigned       pick;
    logic [RadixW-1:0] radix_sel[NumPhases];
    logic              unsigned_sel[NumPhases];
    radix_sel = '{BaseDec, BaseAuto, BaseAuto, BaseHex, BaseHex, RadixW'(2), BaseMax,
                  BaseOct, BaseBad, RadixW'(63), RadixW'(37), BaseAuto};
    unsigned_sel = '{1'b0, 1'b0, 1'b1, 1'b0, 1'b1, 1'b0, 1'b1, 1'b1, 1'b0, 1'b1, 1'b0, 1'b0};
    radix_sel[NumPhases-1]    = RadixW'($urandom);
    unsigned_sel[NumPhases-1] = 1'($urandom_range(0, 1));

    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed strings in decimal, signed mode.
    write_config(BaseDec, 1'b0);
    // A byte without a start flag while idle is ignored.
    queue_byte(ChZero + 8'd5, 1'b0);
    // Mixed whitespace, a minus sign and a high byte as terminator.
    queue_byte(ChTab, 1'b1);
    queue_byte(ChCr, 1'b0);
    queue_byte(ChSpace, 1'b0);
    queue_byte(ChMinus, 1'b0);
    queue_byte(ChZero + 8'd8, 1'b0);
    queue_byte(8'hFF, 1'b0);
    // A sign with no digit after it.
    queue_byte(ChPlus, 1'b1);
    queue_byte(ChLoZ, 1'b0);
    // A restart abandons the first number.
    queue_byte(ChZero + 8'd4, 1'b1);
    queue_byte(ChZero + 8'd2, 1'b1);
    queue_byte(ChZero, 1'b0);
    queue_byte(ChNul, 1'b0);
    // Vertical tab and form feed are whitespace too.
    queue_byte(8'h0B, 1'b1);
    queue_byte(8'h0C, 1'b0);
    queue_byte(ChNine, 1'b0);
    queue_byte(8'h80, 1'b0);
    // An empty string.
    queue_byte(ChNul, 1'b1);

    // Random phases; in one of them the receiver stalls long enough to back up the input.
    for (pick = 0; pick < NumPhases; pick++) begin
      run_phase(radix_sel[pick], unsigned_sel[pick],
                (pick % 3 == 1) ? 0 : GapMax, (pick % 4 == 2) ? 0 : GapMax);
      if (pick == 4) hold_requests++;
    end

    drain();
    if (error_count == 0) begin
      $display("tb_top: clean");
    end else begin
      $display("tb_top: errors");
    end
    $finish;
  end

endmodule
